>>> sv/binary_dilation_3x3_macros.svh
// Assertion macros shared by the dilation block.
// Each use sits inside a module that has clk and rst_n.
`ifndef BINARY_DILATION_3X3_MACROS_SVH
`define BINARY_DILATION_3X3_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset
`define BD3_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define BD3_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define BD3_ASSERT(label, prop, msg)
`define BD3_ASSERT_NEVER(label, expr, msg)

`endif

`endif

>>> sv/bd3_pkg.sv
package bd3_pkg;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Configuration port
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_MASK  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    // Register reset values
    localparam int         WIN_W        = 9;
    localparam logic [8:0] KERNEL_RESET = 9'd186;
    localparam int         WIDTH_RESET  = 10;
    localparam int         HEIGHT_RESET = 10;

    // Stream data width
    localparam int TDATA_W = 8;

    // Window bit groups, row-major with bit 8 top-left
    localparam logic [8:0] WIN_SHIFT_KEEP = 9'h1B6;
    localparam logic [8:0] TOP_ROW_BITS   = 9'h1C0;
    localparam logic [8:0] BOT_ROW_BITS   = 9'h007;
    localparam logic [8:0] LEFT_COL_BITS  = 9'h124;
    localparam logic [8:0] RIGHT_COL_BITS = 9'h049;

    // Per-item control handed from the scan counters to the window stage
    typedef struct packed {
        logic       px;     // effective input pixel
        logic       par;    // row parity, selects the line buffer half
        logic       emit;   // item produces an output pixel
        logic       last;   // output pixel closes the frame
        logic [8:0] keep;   // window bits inside the frame
    } item_t;

    // Turn a 3x3 mask by 180 degrees
    function automatic logic [8:0] reverse9(input logic [8:0] m);
        logic [8:0] r;
        for (int i = 0; i < 9; i++) begin
            r[8-i] = m[i];
        end
        return r;
    endfunction

endpackage

>>> sv/binary_dilation_3x3.sv
// Binary 3x3 dilation of a raster-scanned image. Pixels enter one per
// transaction on the s_ side (s_tdata bit 0 is the pixel, s_tuser marks a
// flush item) and the block takes one transaction every clock while the output
// is not stalled. A dilated pixel is formed in the hold stage from the
// transaction that completes its neighborhood, which is one row plus one pixel
// after its own input (two items for a width of one), and leaves registered on
// the m_ side, so the first width+1 items of a frame give no output and the
// source must send width+1 flush items after each frame; m_tlast marks the
// final pixel of the frame. The rate is set by the single read and write port
// of the two-row line store, one column per clock. After reset the line store
// is cleared while s_tready stays low; configuration writes are taken at any
// time. Pixels outside the frame count as zero. Write the structuring element
// (index 0, bit 8 top-left) and the width and height (indexes 1 and 2, clamped
// to 1..MAX) only while the block is idle; a size write restarts the frame.
module binary_dilation_3x3
    import bd3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,    // [0] pixel, rest zero
    input  logic                  s_tuser,    // [0] flush
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,    // [0] dilated_pixel, rest zero
    output logic                  m_tlast,    // last_of_frame
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             in_accept;
    logic [COL_W-1:0] col;
    item_t            item;
    logic [WIN_W-1:0] kernel_mask;
    logic             restart;
    logic [1:0]       rd_data;
    logic             wr_en;
    logic [1:0]       wr_data;
    logic             busy;
    logic             s1_free;
    logic             out_pixel;

    // Take a transaction when the store is ready and the hold stage frees
    assign s_tready  = !busy && s1_free;
    assign in_accept = s_tvalid && s_tready;

    bd3_scan_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .pixel       (s_tdata[0]),
        .flush       (s_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .col         (col),
        .item        (item),
        .kernel_mask (kernel_mask),
        .restart     (restart)
    );

    bd3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .busy    (busy)
    );

    bd3_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_load     (in_accept),
        .item_in     (item),
        .kernel_mask (kernel_mask),
        .restart     (restart),
        .rd_data     (rd_data),
        .s1_free     (s1_free),
        .wr_en       (wr_en),
        .wr_data     (wr_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_pixel   (out_pixel),
        .out_last    (m_tlast)
    );

    // Pad the result pixel to whole bytes
    assign m_tdata = {{(TDATA_W-1){1'b0}}, out_pixel};

endmodule

>>> sv/bd3_line_buf.sv
`include "binary_dilation_3x3_macros.svh"

module bd3_line_buf
    import bd3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic [1:0]                   rd_data,   // bit p holds the row of parity p
    input  logic                         wr_en,
    input  logic [1:0]                   wr_data,
    output logic                         busy
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [1:0]       line_mem [MAX_WIDTH];
    logic [1:0]       rd_data_reg;
    logic [COL_W-1:0] addr_reg;
    logic             clearing_reg;
    logic [COL_W-1:0] clr_addr_reg;
    logic             bypass;

    // Sweep the store to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + COL_W'(1);
        end
    end

    // Forward a write that lands on the column being read
    assign bypass = wr_en && (addr_reg == rd_addr);

    // Write back at the column last read, read with registered data
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            line_mem[clr_addr_reg] <= 2'b00;
        end
        else if (wr_en)
        begin
            line_mem[addr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bypass ? wr_data : line_mem[rd_addr];
            addr_reg    <= rd_addr;
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

    `BD3_ASSERT_NEVER(a_no_read_in_clear, rd_en && clearing_reg, "line read during clear")
    `BD3_ASSERT_NEVER(a_no_write_in_clear, wr_en && clearing_reg, "line write during clear")

endmodule

>>> sv/bd3_scan_ctrl.sv
`include "binary_dilation_3x3_macros.svh"

module bd3_scan_ctrl
    import bd3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_accept,
    input  logic                         pixel,
    input  logic                         flush,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output item_t                        item,
    output logic [WIN_W-1:0]             kernel_mask,
    output logic                         restart
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WSZ_W   = $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W   = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W  = $clog2(MAX_HEIGHT);
    localparam int WCMP_W  = (CFG_DATA_W > WSZ_W) ? CFG_DATA_W : WSZ_W;
    localparam int HCMP_W  = (CFG_DATA_W > HSZ_W) ? CFG_DATA_W : HSZ_W;
    localparam int W_INIT  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_INIT  = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [WIN_W-1:0]  kernel_reg,  kernel_next;
    logic [WSZ_W-1:0]  width_reg,   width_next;
    logic [HSZ_W-1:0]  height_reg,  height_next;
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;

    logic              col_end;
    logic              row_done;
    logic              emit;
    logic              orow_last;
    logic              ocol_last;
    logic [8:0]        keep;
    logic [WCMP_W-1:0] w_ext;
    logic [HCMP_W-1:0] h_ext;
    logic [WSZ_W-1:0]  w_clamped;
    logic [HSZ_W-1:0]  h_clamped;

    // Clamp written sizes to 1..MAX
    always_comb
    begin
        w_ext = WCMP_W'(cfg_data);
        h_ext = HCMP_W'(cfg_data);
        if (w_ext == '0)
            w_clamped = WSZ_W'(1);
        else if (w_ext > WCMP_W'(MAX_WIDTH))
            w_clamped = WSZ_W'(MAX_WIDTH);
        else
            w_clamped = WSZ_W'(w_ext);
        if (h_ext == '0)
            h_clamped = HSZ_W'(1);
        else if (h_ext > HCMP_W'(MAX_HEIGHT))
            h_clamped = HSZ_W'(MAX_HEIGHT);
        else
            h_clamped = HSZ_W'(h_ext);
    end

    // Position decode for the item at the input
    always_comb
    begin
        col_end   = (WSZ_W'(in_col_reg) + WSZ_W'(1)) >= width_reg;
        row_done  = in_row_reg >= ROW_W'(height_reg);
        emit      = (in_row_reg >= ROW_W'(2))
                 || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        orow_last = (HSZ_W'(out_row_reg) + HSZ_W'(1)) >= height_reg;
        ocol_last = (WSZ_W'(out_col_reg) + WSZ_W'(1)) >= width_reg;

        // Drop window bits that fall outside the frame
        keep = '1;
        if (out_row_reg == '0)
            keep = keep & ~TOP_ROW_BITS;
        if (orow_last)
            keep = keep & ~BOT_ROW_BITS;
        if (out_col_reg == '0)
            keep = keep & ~LEFT_COL_BITS;
        if (ocol_last)
            keep = keep & ~RIGHT_COL_BITS;

        item.px   = pixel && !flush && !row_done;
        item.par  = in_row_reg[0];
        item.emit = emit;
        item.last = emit && orow_last && ocol_last;
        item.keep = keep;
    end

    // Advance positions per transaction, restart on a size write
    always_comb
    begin
        kernel_next  = kernel_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        restart      = 1'b0;

        if (in_accept)
        begin
            if (item.last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (col_end)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (emit)
                begin
                    if (ocol_last)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + OROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
        end

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KERNEL_MASK:
                begin
                    kernel_next = cfg_data[WIN_W-1:0];
                end
                REG_IMAGE_WIDTH:
                begin
                    width_next = w_clamped;
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = h_clamped;
                    restart     = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg  <= KERNEL_RESET;
            width_reg   <= WSZ_W'(W_INIT);
            height_reg  <= HSZ_W'(H_INIT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            kernel_reg  <= kernel_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign col         = in_col_reg;
    assign kernel_mask = kernel_reg;

    `BD3_ASSERT(a_frame_wraps, in_accept && item.last |=> (in_col_reg == '0) && (in_row_reg == '0) && (out_col_reg == '0) && (out_row_reg == '0), "frame end left positions set")
    `BD3_ASSERT(a_col_in_range, in_accept |-> (WSZ_W'(in_col_reg) < width_reg), "input column past width")

endmodule

>>> sv/bd3_window.sv
`include "binary_dilation_3x3_macros.svh"

module bd3_window
    import bd3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_load,
    input  item_t            item_in,
    input  logic [WIN_W-1:0] kernel_mask,
    input  logic             restart,
    input  logic [1:0]       rd_data,
    output logic             s1_free,
    output logic             wr_en,
    output logic [1:0]       wr_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_pixel,
    output logic             out_last
);

    logic             s1_valid_reg;
    item_t            s1_item_reg;
    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win_next;
    logic             out_valid_reg;
    logic             out_pixel_reg;
    logic             out_last_reg;
    logic             s1_fire;
    logic             top;
    logic             mid;
    logic             dilated;

    // Move the held item on unless its result has nowhere to go
    assign s1_fire = s1_valid_reg
                  && (!s1_item_reg.emit || !out_valid_reg || out_ready);
    assign s1_free = !s1_valid_reg || s1_fire;

    // Shift the window one column and OR the turned mask over it
    always_comb
    begin
        top      = rd_data[s1_item_reg.par];
        mid      = rd_data[!s1_item_reg.par];
        win_next = ((win_reg << 1) & WIN_SHIFT_KEEP)
                 | (WIN_W'(top) << 6) | (WIN_W'(mid) << 3) | WIN_W'(s1_item_reg.px);
        dilated  = |(win_next & s1_item_reg.keep & reverse9(kernel_mask));
        wr_data  = s1_item_reg.par ? {s1_item_reg.px, rd_data[0]}
                                   : {rd_data[1], s1_item_reg.px};
    end

    assign wr_en = s1_fire;

    // Hold stage and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            if (in_load)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire && s1_item_reg.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (restart)
                win_reg <= '0;
            else if (s1_fire)
                win_reg <= s1_item_reg.last ? '0 : win_next;
        end
    end

    // Capture item and result payload
    always_ff @(posedge clk)
    begin
        if (in_load)
            s1_item_reg <= item_in;
        if (s1_fire && s1_item_reg.emit)
        begin
            out_pixel_reg <= dilated;
            out_last_reg  <= s1_item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

    `BD3_ASSERT(a_load_when_free, in_load |-> s1_free, "item loaded over a held item")
    `BD3_ASSERT(a_window_cleared, s1_fire && s1_item_reg.last |=> (win_reg == '0), "window kept after frame end")

endmodule
